// ----- sv/bpc_pkg.sv -----
`timescale 1ns / 1ps

package bpc_pkg;

    // register indexes of the configuration port
    localparam logic [2:0] CFG_AC1_AC2 = 3'd0;
    localparam logic [2:0] CFG_AC3_AC4 = 3'd1;
    localparam logic [2:0] CFG_AC5_AC6 = 3'd2;
    localparam logic [2:0] CFG_B1_B2   = 3'd3;
    localparam logic [2:0] CFG_MC_MD   = 3'd4;

    // compensation constants
    localparam logic [31:0] K_B6_OFS   = 32'd4000;
    localparam logic [31:0] K_B4_OFS   = 32'd32768;
    localparam logic [31:0] K_B7_SCALE = 32'd50000;
    localparam logic [31:0] K_C3038    = 32'd3038;
    localparam logic [31:0] K_CM7357   = 32'hFFFF_E343;
    localparam logic [31:0] K_C3791    = 32'd3791;
    localparam logic [17:0] P_MAX      = 18'h3FFFF;
    localparam logic [15:0] T_MAX      = 16'h7FFF;
    localparam logic [15:0] T_MIN      = 16'h8000;

    // calibration coefficients, already widened to 32 bits
    typedef struct packed {
        logic [31:0] ac1;
        logic [31:0] ac2;
        logic [31:0] ac3;
        logic [31:0] ac4;
        logic [31:0] ac5;
        logic [31:0] ac6;
        logic [31:0] b1;
        logic [31:0] b2;
        logic [31:0] mc;
        logic [31:0] md;
    } t_coef;

    // control that travels with a beat between the two halves
    typedef struct packed {
        logic vld;
        logic tfault;
    } t_ctl;

    // arithmetic shift right of a 32-bit word
    function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
        logic signed [31:0] s;
        s = $signed(x);
        return 32'(s >>> n);
    endfunction

endpackage

// ----- sv/bpc_udiv.sv -----
`timescale 1ns / 1ps

module bpc_udiv #(
    parameter int W  = 32,
    parameter int SW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ce,
    input  logic          i_vld,
    input  logic [W-1:0]  i_num,
    input  logic [W-1:0]  i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [W-1:0]  o_quo,
    output logic [SW-1:0] o_side
);

    logic [W-1:0]  r_rem  [0:W];
    logic [W-1:0]  r_num  [0:W];
    logic [W-1:0]  r_quo  [0:W];
    logic [W-1:0]  r_den  [0:W];
    logic [SW-1:0] r_side [0:W];
    logic [W:0]    r_vld;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[W-1:0], i_vld};
        end
    end

    // load stage
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem[0]  <= '0;
            r_num[0]  <= i_num;
            r_quo[0]  <= '0;
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
        end
    end

    // one restoring step per stage, quotient msb first
    for (genvar g = 0; g < W; g++) begin : g_step
        logic [W:0] n_try;
        logic [W:0] n_diff;
        logic       n_ge;
        assign n_try  = {r_rem[g], r_num[g][W-1]};
        assign n_diff = n_try - {1'b0, r_den[g]};
        assign n_ge   = n_try >= {1'b0, r_den[g]};
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[g+1]  <= n_ge ? n_diff[W-1:0] : n_try[W-1:0];
                r_num[g+1]  <= {r_num[g][W-2:0], 1'b0};
                r_quo[g+1]  <= {r_quo[g][W-2:0], n_ge};
                r_den[g+1]  <= r_den[g];
                r_side[g+1] <= r_side[g];
            end
        end
    end

    assign o_vld  = r_vld[W];
    assign o_quo  = r_quo[W];
    assign o_side = r_side[W];

endmodule

// ----- sv/bpc_temp.sv -----
`timescale 1ns / 1ps

module bpc_temp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_ce,
    input  logic           i_vld,
    input  logic [15:0]    i_ut,
    input  logic [15:0]    i_up,
    input  bpc_pkg::t_coef i_coef,
    output bpc_pkg::t_ctl  o_ctl,
    output logic [31:0]    o_b6,
    output logic [15:0]    o_up,
    output logic [15:0]    o_temp
);
    import bpc_pkg::*;

    localparam int SW = 16 + 32 + 2;

    logic        r1_vld, r2_vld, r3_vld, r5_vld, r6_vld;
    logic [15:0] r1_ut, r1_up, r2_up, r3_up, r5_up, r6_up;
    logic [31:0] r2_m0, r3_x1, r3_den, r5_b5, r6_b6;
    logic        r5_dz, r6_dz;
    logic [15:0] r6_temp;

    logic [31:0] n_d0, n_x1, n_num, n_nmag, n_dmag, n_q, n_x2, n_b5, n_t;
    logic        n_neg, n_dz, d_vld, d_neg, d_dz;
    logic [31:0] d_quo, d_x1;
    logic [15:0] d_up, n_temp;
    logic [SW-1:0] d_side;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else if (i_ce) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r5_vld <= d_vld;
            r6_vld <= r5_vld;
        end
    end

    // ut - ac6 times ac5, then x1 and the divisor
    assign n_d0 = {16'd0, r1_ut} - i_coef.ac6;
    assign n_x1 = asr32(r2_m0, 15);

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_ut  <= i_ut;
            r1_up  <= i_up;
            r2_m0  <= n_d0 * i_coef.ac5;
            r2_up  <= r1_up;
            r3_x1  <= n_x1;
            r3_den <= n_x1 + i_coef.md;
            r3_up  <= r2_up;
        end
    end

    // signed divide of mc * 2048 by the divisor as magnitudes
    assign n_num  = {i_coef.mc[20:0], 11'd0};
    assign n_neg  = n_num[31] ^ r3_den[31];
    assign n_nmag = n_num[31] ? 32'(-n_num) : n_num;
    assign n_dmag = r3_den[31] ? 32'(-r3_den) : r3_den;
    assign n_dz   = r3_den == 32'd0;

    bpc_udiv #(.W(32), .SW(SW)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ce   (i_ce),
        .i_vld  (r3_vld),
        .i_num  (n_nmag),
        .i_den  (n_dmag),
        .i_side ({r3_up, r3_x1, n_neg, n_dz}),
        .o_vld  (d_vld),
        .o_quo  (d_quo),
        .o_side (d_side)
    );

    assign {d_up, d_x1, d_neg, d_dz} = d_side;
    assign n_q  = d_neg ? 32'(-d_quo) : d_quo;
    assign n_x2 = n_q;
    assign n_b5 = d_x1 + n_x2;

    // temperature with saturation
    assign n_t = asr32(r5_b5 + 32'd8, 4);
    always_comb begin
        if (r5_dz) begin
            n_temp = i_coef.mc[31] ? T_MIN : T_MAX;
        end else if (!n_t[31] && n_t[30:15] != 16'd0) begin
            n_temp = T_MAX;
        end else if (n_t[31] && n_t[30:15] != 16'hFFFF) begin
            n_temp = T_MIN;
        end else begin
            n_temp = n_t[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r5_b5   <= n_b5;
            r5_up   <= d_up;
            r5_dz   <= d_dz;
            r6_b6   <= r5_b5 - K_B6_OFS;
            r6_up   <= r5_up;
            r6_dz   <= r5_dz;
            r6_temp <= n_temp;
        end
    end

    assign o_ctl.vld    = r6_vld;
    assign o_ctl.tfault = r6_dz;
    assign o_b6         = r6_b6;
    assign o_up         = r6_up;
    assign o_temp       = r6_temp;

endmodule

// ----- sv/bpc_press.sv -----
`timescale 1ns / 1ps

module bpc_press (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_ce,
    input  bpc_pkg::t_ctl  i_ctl,
    input  logic [31:0]    i_b6,
    input  logic [15:0]    i_up,
    input  logic [15:0]    i_temp,
    input  bpc_pkg::t_coef i_coef,
    output logic           o_vld,
    output logic [15:0]    o_temp,
    output logic [31:0]    o_p,
    output logic           o_tfault,
    output logic           o_pfault
);
    import bpc_pkg::*;

    localparam int NS = 6;
    localparam int SW = 16 + 3;

    logic [NS:1]  r_vld;
    logic [3:0]   r_pvld;
    logic [15:0]  r_temp [1:NS];
    logic         r_tf   [1:NS];
    logic [15:0]  r_up   [1:4];
    logic [31:0]  r1_msq, r1_ma2, r1_ma3, r2_sq, r2_x2a, r2_x1c;
    logic [31:0]  r3_mb2, r3_mb1, r3_x2a, r3_x1c, r4_b3, r4_x3;
    logic [31:0]  r5_mb4, r5_diff, r6_b4, r6_mb7;
    logic [31:0]  r8_p, r9_msq, r9_mc, r9_p, r10_mx1, r10_x2, r10_p, r11_p;
    logic [15:0]  r8_temp, r9_temp, r10_temp, r11_temp;
    logic         r8_tf, r9_tf, r10_tf, r11_tf, r8_bz, r9_bz, r10_bz, r11_bz;

    logic [31:0]  n_x1, n_b3, n_x3, n_num, n_s, d_quo, n_x1b;
    logic         n_big, n_bz, d_vld, d_tf, d_bz, d_big;
    logic [15:0]  d_temp;
    logic [SW-1:0] d_side;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_pvld <= '0;
        end else if (i_ce) begin
            r_vld  <= {r_vld[NS-1:1], i_ctl.vld};
            r_pvld <= {r_pvld[2:0], d_vld};
        end
    end

    // sideband ahead of the divider
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_temp[1] <= i_temp;
            r_tf[1]   <= i_ctl.tfault;
            r_up[1]   <= i_up;
            for (int k = 2; k <= NS; k++) begin
                r_temp[k] <= r_temp[k-1];
                r_tf[k]   <= r_tf[k-1];
            end
            for (int k = 2; k <= 4; k++) begin
                r_up[k] <= r_up[k-1];
            end
        end
    end

    // b3 and x3 from b6
    assign n_x1 = asr32(r3_mb2, 11);
    assign n_b3 = asr32({i_coef.ac1[29:0], 2'b00} + n_x1 + r3_x2a + 32'd2, 2);
    assign n_x3 = asr32(r3_x1c + asr32(r3_mb1, 16) + 32'd2, 2);

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_msq  <= i_b6 * i_b6;
            r1_ma2  <= i_coef.ac2 * i_b6;
            r1_ma3  <= i_coef.ac3 * i_b6;
            r2_sq   <= asr32(r1_msq, 12);
            r2_x2a  <= asr32(r1_ma2, 11);
            r2_x1c  <= asr32(r1_ma3, 13);
            r3_mb2  <= i_coef.b2 * r2_sq;
            r3_mb1  <= i_coef.b1 * r2_sq;
            r3_x2a  <= r2_x2a;
            r3_x1c  <= r2_x1c;
            r4_b3   <= n_b3;
            r4_x3   <= n_x3;
            r5_mb4  <= i_coef.ac4 * (r4_x3 + K_B4_OFS);
            r5_diff <= {16'd0, r_up[4]} - r4_b3;
            r6_b4   <= r5_mb4 >> 15;
            r6_mb7  <= r5_diff * K_B7_SCALE;
        end
    end

    // b7 / b4, doubled before or after depending on the top bit of b7
    assign n_big = r6_mb7[31];
    assign n_num = n_big ? r6_mb7 : {r6_mb7[30:0], 1'b0};
    assign n_bz  = r6_b4 == 32'd0;

    bpc_udiv #(.W(32), .SW(SW)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ce   (i_ce),
        .i_vld  (r_vld[NS]),
        .i_num  (n_num),
        .i_den  (r6_b4),
        .i_side ({r_temp[NS], r_tf[NS], n_bz, n_big}),
        .o_vld  (d_vld),
        .o_quo  (d_quo),
        .o_side (d_side)
    );

    assign {d_temp, d_tf, d_bz, d_big} = d_side;

    // final pressure correction
    assign n_s   = asr32(r8_p, 8);
    assign n_x1b = asr32(r10_mx1, 16);

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r8_p     <= d_big ? {d_quo[30:0], 1'b0} : d_quo;
            r8_temp  <= d_temp;
            r8_tf    <= d_tf;
            r8_bz    <= d_bz;
            r9_msq   <= n_s * n_s;
            r9_mc    <= K_CM7357 * r8_p;
            r9_p     <= r8_p;
            r9_temp  <= r8_temp;
            r9_tf    <= r8_tf;
            r9_bz    <= r8_bz;
            r10_mx1  <= r9_msq * K_C3038;
            r10_x2   <= asr32(r9_mc, 16);
            r10_p    <= r9_p;
            r10_temp <= r9_temp;
            r10_tf   <= r9_tf;
            r10_bz   <= r9_bz;
            r11_p    <= r10_p + asr32(n_x1b + r10_x2 + K_C3791, 4);
            r11_temp <= r10_temp;
            r11_tf   <= r10_tf;
            r11_bz   <= r10_bz;
        end
    end

    assign o_vld    = r_pvld[3];
    assign o_temp   = r11_temp;
    assign o_p      = r11_p;
    assign o_tfault = r11_tf;
    assign o_pfault = r11_bz;

endmodule

// ----- sv/barometric_pressure_compensation.sv -----
`timescale 1ns / 1ps

// channel  | dir | fields (lsb up)
// s_axis   | in  | tdata: raw_temperature[15:0], raw_pressure[31:16]
// m_axis   | out | tdata: temperature_tenths[15:0], pressure_pa[33:16]; tuser: divide_fault
// cfg      | in  | wen, idx (0..4), wdata 32 bits, no read-back
//
// one beat per cycle sustained while the output is not stalled; the path runs through
// the two pipelined restoring dividers, one quotient bit per stage, plus multiplier stages
// the whole pipeline advances together whenever the output register is empty
// or being taken; a stall at the output holds every stage
// reset is synchronous and clears the valid bits and the coefficients

module barometric_pressure_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // raw_temperature, raw_pressure
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // temperature_tenths, pressure_pa, zero fill
    output logic        o_m_axis_tuser,   // divide_fault
    input  logic        i_cfg_wen,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata
);
    import bpc_pkg::*;

    logic [31:0] r_ac12, r_ac34, r_ac56, r_b12, r_mcmd;
    t_coef       n_coef;
    logic        n_ce, p_vld, p_tf, p_pf, r_out_vld, n_fault;
    t_ctl        t_ctl_o;
    logic [31:0] t_b6, p_p;
    logic [15:0] t_up, t_temp, p_temp, r_temp;
    logic [17:0] n_press, r_press;
    logic        r_fault;

    // coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac12 <= '0;
            r_ac34 <= '0;
            r_ac56 <= '0;
            r_b12  <= '0;
            r_mcmd <= '0;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                CFG_AC1_AC2: r_ac12 <= i_cfg_wdata;
                CFG_AC3_AC4: r_ac34 <= i_cfg_wdata;
                CFG_AC5_AC6: r_ac56 <= i_cfg_wdata;
                CFG_B1_B2:   r_b12  <= i_cfg_wdata;
                CFG_MC_MD:   r_mcmd <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // widen the halves
    always_comb begin
        n_coef.ac1 = {{16{r_ac12[31]}}, r_ac12[31:16]};
        n_coef.ac2 = {{16{r_ac12[15]}}, r_ac12[15:0]};
        n_coef.ac3 = {{16{r_ac34[31]}}, r_ac34[31:16]};
        n_coef.ac4 = {16'd0, r_ac34[15:0]};
        n_coef.ac5 = {16'd0, r_ac56[31:16]};
        n_coef.ac6 = {16'd0, r_ac56[15:0]};
        n_coef.b1  = {{16{r_b12[31]}}, r_b12[31:16]};
        n_coef.b2  = {{16{r_b12[15]}}, r_b12[15:0]};
        n_coef.mc  = {{16{r_mcmd[31]}}, r_mcmd[31:16]};
        n_coef.md  = {{16{r_mcmd[15]}}, r_mcmd[15:0]};
    end

    // pipeline advance
    assign n_ce            = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = n_ce;

    bpc_temp u_temp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ce   (n_ce),
        .i_vld  (i_s_axis_tvalid),
        .i_ut   (i_s_axis_tdata[15:0]),
        .i_up   (i_s_axis_tdata[31:16]),
        .i_coef (n_coef),
        .o_ctl  (t_ctl_o),
        .o_b6   (t_b6),
        .o_up   (t_up),
        .o_temp (t_temp)
    );

    bpc_press u_press (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (n_ce),
        .i_ctl   (t_ctl_o),
        .i_b6    (t_b6),
        .i_up    (t_up),
        .i_temp  (t_temp),
        .i_coef  (n_coef),
        .o_vld   (p_vld),
        .o_temp  (p_temp),
        .o_p     (p_p),
        .o_tfault(p_tf),
        .o_pfault(p_pf)
    );

    // pressure saturation
    assign n_fault = p_tf || p_pf;
    always_comb begin
        if (n_fault || (!p_p[31] && p_p[30:18] != 13'd0)) begin
            n_press = P_MAX;
        end else if (p_p[31]) begin
            n_press = '0;
        end else begin
            n_press = p_p[17:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (n_ce) begin
            r_out_vld <= p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_ce) begin
            r_temp  <= p_temp;
            r_press <= n_press;
            r_fault <= n_fault;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {6'd0, r_press, r_temp};
    assign o_m_axis_tuser  = r_fault;

endmodule

// ----- sv/bpc_checker.sv -----
`timescale 1ns / 1ps

module bpc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result beat changed under stall");

    // an empty output stage never blocks the input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output");

    // a divide fault always forces full-scale pressure
    a_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata[33:16] == 18'h3FFFF)
        else $error("fault without saturated pressure");

    // no result straight after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_s_axis_tready(o_s_axis_tready),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata),
    .o_m_axis_tuser (o_m_axis_tuser)
);
